/* design/fpclip_pkg.sv */
package fpclip_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned NUM_WORDS = 6;
  localparam int unsigned DIST_W = 34;

  localparam logic [2:0] PLANE_LEFT   = 3'd0;
  localparam logic [2:0] PLANE_RIGHT  = 3'd1;
  localparam logic [2:0] PLANE_BOTTOM = 3'd2;
  localparam logic [2:0] PLANE_TOP    = 3'd3;
  localparam logic [2:0] PLANE_NEAR   = 3'd4;
  localparam logic [2:0] PLANE_FAR    = 3'd5;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t [NUM_WORDS-1:0] vtx_t;

  // Edge job handed from the front to the back.
  typedef struct packed {
    vtx_t a;
    vtx_t b;
    logic signed [DIST_W-1:0] da;
    logic signed [DIST_W-1:0] db;
    logic ia;
    logic ib;
    logic single;
    logic close;
  } edge_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_PUSHQ,
    BK_PUSHB,
    BK_FLUSH
  } bk_state_t;

  function automatic logic signed [DIST_W-1:0] dist_of(vtx_t v, logic [2:0] pl);
    logic signed [DIST_W-1:0] x, y, z, w, d;
    x = DIST_W'(v[0]);
    y = DIST_W'(v[1]);
    z = DIST_W'(v[2]);
    w = DIST_W'(v[3]);
    unique case (pl)
      PLANE_LEFT:   d = x + w;
      PLANE_RIGHT:  d = w - x;
      PLANE_BOTTOM: d = y + w;
      PLANE_TOP:    d = w - y;
      PLANE_NEAR:   d = z + w;
      PLANE_FAR:    d = w - z;
      default:      d = -DIST_W'(1);
    endcase
    return d;
  endfunction

endpackage

/* design/fpclip_front.sv */
module fpclip_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          plane,
  input  logic                in_valid,
  output logic                in_ready,
  input  fpclip_pkg::vtx_t    in_vtx,
  input  logic                in_lst,
  output logic                q_push,
  output fpclip_pkg::edge_t   q_data0,
  output logic                q_two,
  output fpclip_pkg::edge_t   q_data1,
  input  logic [1:0]          q_room
);

  fpclip_pkg::vtx_t first_r, first_nxt, prev_r, prev_nxt;
  logic seen_r, seen_nxt;
  logic signed [fpclip_pkg::DIST_W-1:0] dv, dp, df;

  always_comb begin
    dv = fpclip_pkg::dist_of(in_vtx, plane);
    dp = fpclip_pkg::dist_of(prev_r, plane);
    df = fpclip_pkg::dist_of(first_r, plane);
    in_ready = (q_room == 2'd2);
    q_push = in_valid && in_ready && (seen_r || in_lst);
    q_two = seen_r && in_lst;
    q_data0.a = prev_r;
    q_data0.b = in_vtx;
    q_data0.da = dp;
    q_data0.db = dv;
    q_data0.ia = (dp >= 0) && (plane <= fpclip_pkg::PLANE_FAR);
    q_data0.ib = (dv >= 0) && (plane <= fpclip_pkg::PLANE_FAR);
    q_data0.single = !seen_r;
    q_data0.close = !seen_r;
    q_data1.a = in_vtx;
    q_data1.b = first_r;
    q_data1.da = dv;
    q_data1.db = df;
    q_data1.ia = q_data0.ib;
    q_data1.ib = (df >= 0) && (plane <= fpclip_pkg::PLANE_FAR);
    q_data1.single = 1'b0;
    q_data1.close = 1'b1;
    first_nxt = first_r;
    prev_nxt = prev_r;
    seen_nxt = seen_r;
    if (in_valid && in_ready) begin
      prev_nxt = in_vtx;
      if (!seen_r) first_nxt = in_vtx;
      seen_nxt = !in_lst;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    prev_r <= prev_nxt;
    if (!rst_n) seen_r <= 1'b0;
    else seen_r <= seen_nxt;
  end

endmodule

/* design/fpclip_queue.sv */
module fpclip_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fpclip_pkg::edge_t d0,
  input  logic              two,
  input  fpclip_pkg::edge_t d1,
  output logic [1:0]        room,
  output logic              pop_valid,
  output fpclip_pkg::edge_t pop_data,
  input  logic              pop
);

  fpclip_pkg::edge_t mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    room = 2'd2 - cnt_r;
    pop_valid = (cnt_r != 2'd0);
    pop_data = mem_r[0];
    cnt_nxt = cnt_r - {1'b0, pop} + (push ? (two ? 2'd2 : 2'd1) : 2'd0);
  end

  // Entry 0 is the head; pushes happen only into an empty queue.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[0] <= d0;
      mem_r[1] <= d1;
    end else if (pop) begin
      mem_r[0] <= mem_r[1];
    end
    if (!rst_n) cnt_r <= 2'd0;
    else cnt_r <= cnt_nxt;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r == 2'd0) else $error("push into busy queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid) else $error("pop from empty queue");
`endif

endmodule

/* design/fpclip_back.sv */
module fpclip_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  fpclip_pkg::edge_t job,
  output logic              job_pop,
  output logic              res_valid,
  input  logic              res_ready,
  output fpclip_pkg::vtx_t  res_vtx,
  output logic              res_empty,
  output logic              res_last
);

  localparam int NUM_W = fpclip_pkg::DIST_W + FRAC_BITS;
  localparam int T_W = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int PROD_W = fpclip_pkg::WORD_W + 1 + T_W + 1;

  fpclip_pkg::bk_state_t st_r, st_nxt;
  fpclip_pkg::edge_t job_r, job_nxt;
  fpclip_pkg::vtx_t hold_r, hold_nxt, q_r, q_nxt;
  logic held_r, held_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [fpclip_pkg::DIST_W:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0] wi_r, wi_nxt;
  logic ov_r, ov_nxt;
  fpclip_pkg::vtx_t ov_vtx_r, ov_vtx_nxt;
  logic ov_empty_r, ov_empty_nxt, ov_last_r, ov_last_nxt;
  logic [fpclip_pkg::DIST_W:0] rem_sh;
  logic signed [fpclip_pkg::WORD_W:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [fpclip_pkg::WORD_W:0] step;
  logic [fpclip_pkg::DIST_W-1:0] num_abs, den_abs;
  logic signed [fpclip_pkg::DIST_W-1:0] dd;
  logic out_free;

  always_comb begin
    out_free = !ov_r || res_ready;
    res_valid = ov_r;
    res_vtx = ov_vtx_r;
    res_empty = ov_empty_r;
    res_last = ov_last_r;
    st_nxt = st_r;
    job_nxt = job_r;
    hold_nxt = hold_r;
    held_nxt = held_r;
    q_nxt = q_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    wi_nxt = wi_r;
    ov_nxt = ov_r && !res_ready;
    ov_vtx_nxt = ov_vtx_r;
    ov_empty_nxt = ov_empty_r;
    ov_last_nxt = ov_last_r;
    job_pop = 1'b0;
    dd = job.da - job.db;
    num_abs = job.da[fpclip_pkg::DIST_W-1] ? -job.da : job.da;
    den_abs = dd[fpclip_pkg::DIST_W-1] ? -dd : dd;
    rem_sh = {rem_r[fpclip_pkg::DIST_W-1:0], quo_r[NUM_W-1]};
    diff = {job_r.b[wi_r][fpclip_pkg::WORD_W-1], job_r.b[wi_r]}
         - {job_r.a[wi_r][fpclip_pkg::WORD_W-1], job_r.a[wi_r]};
    prod = PROD_W'(diff) * PROD_W'($signed({1'b0, quo_r[T_W-1:0]}));
    step = (fpclip_pkg::WORD_W+1)'(prod >>> FRAC_BITS);
    unique case (st_r)
      fpclip_pkg::BK_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          job_nxt = job;
          if (job.single) begin
            st_nxt = fpclip_pkg::BK_FLUSH;
            held_nxt = job.ib;
            hold_nxt = job.ib ? job.b : '0;
          end else if (job.ia != job.ib) begin
            st_nxt = fpclip_pkg::BK_DIV;
            quo_nxt = {num_abs, FRAC_BITS'(0)};
            rem_nxt = '0;
            den_nxt = {1'b0, den_abs};
            cnt_nxt = CNT_W'(NUM_W);
          end else if (job.ib) begin
            st_nxt = fpclip_pkg::BK_PUSHB;
          end else if (job.close) begin
            st_nxt = fpclip_pkg::BK_FLUSH;
          end
        end
      end
      fpclip_pkg::BK_DIV: begin
        // One quotient bit per cycle, restoring.
        if (rem_sh >= den_r) begin
          rem_nxt = rem_sh - den_r;
          quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          st_nxt = fpclip_pkg::BK_MUL;
          wi_nxt = '0;
          if (den_r == '0) quo_nxt = '0;
        end
      end
      fpclip_pkg::BK_MUL: begin
        q_nxt[wi_r] = fpclip_pkg::WORD_W'(
          {job_r.a[wi_r][fpclip_pkg::WORD_W-1], job_r.a[wi_r]} + step);
        wi_nxt = wi_r + 1'b1;
        if (wi_r == 3'(fpclip_pkg::NUM_WORDS - 1)) st_nxt = fpclip_pkg::BK_PUSHQ;
      end
      fpclip_pkg::BK_PUSHQ: begin
        if (out_free) begin
          if (held_r) begin
            ov_nxt = 1'b1;
            ov_vtx_nxt = hold_r;
            ov_empty_nxt = 1'b0;
            ov_last_nxt = 1'b0;
          end
          hold_nxt = q_r;
          held_nxt = 1'b1;
          if (job_r.ib) st_nxt = fpclip_pkg::BK_PUSHB;
          else if (job_r.close) st_nxt = fpclip_pkg::BK_FLUSH;
          else st_nxt = fpclip_pkg::BK_IDLE;
        end
      end
      fpclip_pkg::BK_PUSHB: begin
        if (out_free) begin
          if (held_r) begin
            ov_nxt = 1'b1;
            ov_vtx_nxt = hold_r;
            ov_empty_nxt = 1'b0;
            ov_last_nxt = 1'b0;
          end
          hold_nxt = job_r.b;
          held_nxt = 1'b1;
          st_nxt = job_r.close ? fpclip_pkg::BK_FLUSH : fpclip_pkg::BK_IDLE;
        end
      end
      fpclip_pkg::BK_FLUSH: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          ov_vtx_nxt = held_r ? hold_r : '0;
          ov_empty_nxt = !held_r;
          ov_last_nxt = 1'b1;
          held_nxt = 1'b0;
          st_nxt = fpclip_pkg::BK_IDLE;
        end
      end
      default: st_nxt = fpclip_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    hold_r <= hold_nxt;
    q_r <= q_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    wi_r <= wi_nxt;
    ov_vtx_r <= ov_vtx_nxt;
    ov_empty_r <= ov_empty_nxt;
    ov_last_r <= ov_last_nxt;
    if (!rst_n) begin
      st_r <= fpclip_pkg::BK_IDLE;
      held_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      held_r <= held_nxt;
      ov_r <= ov_nxt;
    end
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid) else $error("result dropped");
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_empty |-> res_last) else $error("empty without last");
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == fpclip_pkg::BK_FLUSH && out_free |=> !held_r)
    else $error("hold not cleared");
`endif

endmodule

/* design/frustum_plane_polygon_clip_unit.sv */
// Sutherland-Hodgman clip of one polygon against one clip-space plane.
// Input channel (in_): one vertex word per handshake, tlast marks the
// final vertex of a polygon. Output channel (out_): clipped vertices;
// tlast marks the last word of each polygon, tuser flags a polygon that
// was clipped away entirely (vertex fields are zero then).
// cfg_we/cfg_wdata write the plane select (0 left .. 5 far; 6 and 7 clip
// everything). Write it only while the block is idle.
// The front computes plane distances and queues edge jobs; the back runs
// one edge at a time. A crossing edge passes through the bit-serial
// divider, then a multiply step for each of the six words, then the push
// states; an edge with no crossing skips the divider and multiplier. The last
// vertex also queues the closing edge. A new vertex is taken once the
// queue is empty, so a vertex waits for the back to start the edges of
// the previous one. Results leave one word late through a holding register
// so the final word can carry tlast.
// Reset clears the queue, the holding register and the output register.
// A stalled receiver holds out_tdata steady; the back waits at its next push,
// the queue stops draining, and in_tready then stays low.
module frustum_plane_polygon_clip_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,   // pos_x, pos_y, pos_z, pos_w, attr_u, attr_v
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // out_x, out_y, out_z, out_w, out_u, out_v
  output logic         out_tuser,  // out_empty
  output logic         out_tlast
);

  logic [2:0] plane_r;
  fpclip_pkg::vtx_t in_vtx, res_vtx;
  fpclip_pkg::edge_t d0, d1, head;
  logic push, two, hv, pop;
  logic [1:0] room;

  always_ff @(posedge clk) begin
    if (!rst_n) plane_r <= fpclip_pkg::PLANE_LEFT;
    else if (cfg_we) plane_r <= cfg_wdata;
  end

  assign in_vtx = in_tdata;
  assign out_tdata = res_vtx;

  fpclip_front u_front (
    .clk, .rst_n, .plane(plane_r), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_vtx, .in_lst(in_tlast), .q_push(push), .q_data0(d0), .q_two(two),
    .q_data1(d1), .q_room(room)
  );

  fpclip_queue u_queue (
    .clk, .rst_n, .push, .d0, .two, .d1, .room, .pop_valid(hv),
    .pop_data(head), .pop
  );

  fpclip_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .job_valid(hv), .job(head), .job_pop(pop),
    .res_valid(out_tvalid), .res_ready(out_tready), .res_vtx,
    .res_empty(out_tuser), .res_last(out_tlast)
  );

endmodule

/* sim/tb_frustum_plane_polygon_clip_unit.sv */
module tb_frustum_plane_polygon_clip_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [63:0] wide_t;
  typedef wide_t [fpclip_pkg::NUM_WORDS-1:0] wvtx_t;

  // One vertex word as offered on the input channel.
  typedef struct {
    logic [191:0] data;
    logic         last;
  } vin_t;

  // One clipped vertex word as it must leave the block.
  typedef struct {
    logic [191:0] data;
    logic         empty;
    logic         last;
  } vout_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [2:0]   cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [191:0] in_tdata;   // pos_x, pos_y, pos_z, pos_w, attr_u, attr_v
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;  // out_x, out_y, out_z, out_w, out_u, out_v
  logic         out_tuser;  // out_empty
  logic         out_tlast;

  frustum_plane_polygon_clip_unit u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  vin_t  vertex_queue[$];
  vout_t clipped_queue[$];
  int    fails = 0;
  int    sent_items = 0;
  bit    no_idle = 0;
  bit    hold_trig = 0;

  // Clipper state mirrored by the testbench.
  logic [2:0] cur_plane;
  wvtx_t      first_v, prev_v, hold_v;
  int         seen_cnt;
  bit         hold_ok;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Signed plane distance; codes past the far plane put every vertex outside.
  function automatic wide_t plane_dist(wvtx_t v);
    case (cur_plane)
      fpclip_pkg::PLANE_LEFT:   return v[0] + v[3];
      fpclip_pkg::PLANE_RIGHT:  return v[3] - v[0];
      fpclip_pkg::PLANE_BOTTOM: return v[1] + v[3];
      fpclip_pkg::PLANE_TOP:    return v[3] - v[1];
      fpclip_pkg::PLANE_NEAR:   return v[2] + v[3];
      fpclip_pkg::PLANE_FAR:    return v[3] - v[2];
      default:                  return -64'sd1;
    endcase
  endfunction

  function automatic logic [191:0] pack_vtx(wvtx_t v);
    logic [191:0] d;
    for (int i = 0; i < fpclip_pkg::NUM_WORDS; i++) d[i*32 +: 32] = v[i][31:0];
    return d;
  endfunction

  task automatic queue_word(wvtx_t v, bit empty, bit last);
    vout_t r;
    r.data = empty ? '0 : pack_vtx(v);
    r.empty = empty;
    r.last = last;
    clipped_queue = {clipped_queue, r};
  endtask

  // Results leave one word late so the final one can carry tlast.
  task automatic push_clipped(wvtx_t v);
    if (hold_ok) queue_word(hold_v, 0, 0);
    hold_v = v;
    hold_ok = 1;
  endtask

  task automatic clip_edge(wvtx_t a, wvtx_t b);
    wide_t da, db, num, den, t;
    wvtx_t q;
    bit ia, ib;
    da = plane_dist(a);
    db = plane_dist(b);
    ia = da >= 0;
    ib = db >= 0;
    if (ia && ib) begin
      push_clipped(b);
    end else if (ia != ib) begin
      num = da < 0 ? -da : da;
      den = (da - db) < 0 ? db - da : da - db;
      t = (num <<< 16) / den;
      for (int i = 0; i < fpclip_pkg::NUM_WORDS; i++)
        q[i] = a[i] + (((b[i] - a[i]) * t) >>> 16);
      push_clipped(q);
      if (ib) push_clipped(b);
    end
  endtask

  // Predict the results of one vertex and queue it for the driver.
  task automatic send_vertex(wvtx_t v, bit last);
    vin_t it;
    it.data = pack_vtx(v);
    it.last = last;
    vertex_queue = {vertex_queue, it};
    sent_items++;
    if (seen_cnt == 0) begin
      if (last) begin
        if (plane_dist(v) >= 0) queue_word(v, 0, 1);
        else queue_word(v, 1, 1);
        hold_ok = 0;
      end else begin
        first_v = v;
        prev_v = v;
        seen_cnt = 1;
        hold_ok = 0;
      end
      return;
    end
    clip_edge(prev_v, v);
    if (last) begin
      clip_edge(v, first_v);
      if (hold_ok) queue_word(hold_v, 0, 1);
      else queue_word(hold_v, 1, 1);
      hold_ok = 0;
      seen_cnt = 0;
    end else begin
      prev_v = v;
      seen_cnt = 2;
    end
  endtask

  function automatic wide_t rand_word(int mode);
    case (mode)
      0: return wide_t'($signed($urandom));
      1: return wide_t'($signed(32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000));
      default: return wide_t'($signed(32'($urandom_range(0, 32'h0004_0000))));
    endcase
  endfunction

  function automatic wvtx_t rand_vtx();
    wvtx_t v;
    int mode;
    mode = ($urandom_range(0, 9) < 2) ? 0 : 1;
    for (int i = 0; i < fpclip_pkg::NUM_WORDS; i++) v[i] = rand_word(mode);
    // Keep w non-negative so about half the vertices fall inside.
    if (mode == 1) v[3] = rand_word(2);
    return v;
  endfunction

  function automatic wvtx_t mk_vtx(int x, int y, int z, int w, int u, int vv);
    wvtx_t v;
    v[0] = x; v[1] = y; v[2] = z; v[3] = w; v[4] = u; v[5] = vv;
    return v;
  endfunction

  task automatic send_poly(int n);
    for (int i = 0; i < n; i++) send_vertex(rand_vtx(), i == n - 1);
  endtask

  // Let the pipe drain, then write the plane while the block is idle.
  task automatic set_plane(logic [2:0] p);
    while (vertex_queue.size() != 0 || clipped_queue.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= p;
    @(negedge clk);
    cfg_we <= 0;
    cur_plane = p;
  endtask

  initial begin
    int budget;
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = fpclip_pkg::PLANE_LEFT;
    cur_plane = fpclip_pkg::PLANE_LEFT;
    seen_cnt = 0;
    hold_ok = 0;
    hold_v = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1;

    // Directed: single vertices, fully inside/outside, crossings, extremes.
    set_plane(fpclip_pkg::PLANE_LEFT);
    send_vertex(mk_vtx(0, 0, 0, 32'h10000, 1, 2), 1);
    send_vertex(mk_vtx(-32'h20000, 0, 0, 32'h10000, 3, 4), 1);
    send_vertex(mk_vtx(0, 0, 0, 32'h10000, 5, 6), 0);
    send_vertex(mk_vtx(32'h8000, 0, 0, 32'h10000, 7, 8), 0);
    send_vertex(mk_vtx(0, 32'h8000, 0, 32'h10000, 9, 10), 1);
    send_vertex(mk_vtx(-32'h30000, 0, 0, 32'h10000, 1, 1), 0);
    send_vertex(mk_vtx(-32'h30000, 5, 0, 32'h10000, 2, 2), 0);
    send_vertex(mk_vtx(-32'h30000, 9, 0, 32'h10000, 3, 3), 1);
    send_vertex(mk_vtx(-32'h30000, 0, 0, 32'h10000, 0, 0), 0);
    send_vertex(mk_vtx(32'h10000, 0, 0, 32'h10000, 32'h7fffffff, -32'sh80000000), 0);
    send_vertex(mk_vtx(0, 32'h10000, 0, 32'h10000, -32'sh80000000, 32'h7fffffff), 1);
    send_vertex(mk_vtx(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, -1, -1), 0);
    send_vertex(mk_vtx(-32'sh80000000, -32'sh80000000, -32'sh80000000, -32'sh80000000,
                       32'h7fffffff, -32'sh80000000), 1);
    send_vertex(mk_vtx(-32'sh80000000, 0, 0, 32'h7fffffff, 0, -1), 0);
    send_vertex(mk_vtx(32'h7fffffff, 0, 0, -32'sh80000000, -1, 0), 1);
    set_plane(3'd7);
    send_vertex(mk_vtx(0, 0, 0, 32'h10000, 1, 2), 0);
    send_vertex(mk_vtx(1, 0, 0, 32'h10000, 1, 2), 0);
    send_vertex(mk_vtx(0, 1, 0, 32'h10000, 1, 2), 1);
    send_vertex(mk_vtx(0, 0, 0, 32'h10000, 1, 2), 1);

    // Random: every plane code, then random codes; one phase with no idle gaps, one long stall.
    for (int ph = 0; sent_items < 290; ph++) begin
      set_plane(ph < 8 ? 3'(ph) : 3'($urandom_range(0, 5)));
      no_idle = (ph == 2);
      if (ph == 4) hold_trig = ~hold_trig;
      budget = sent_items + 30;
      while (sent_items < budget) begin
        if ($urandom_range(0, 9) == 0) send_poly($urandom_range(1, 2));
        else send_poly($urandom_range(3, 7));
      end
    end
    no_idle = 0;

    while (vertex_queue.size() != 0 || clipped_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Driver: present the next word at the falling edge, drop it once taken.
  bit   in_taken = 0;
  vin_t cur_item;
  always @(posedge clk) in_taken <= rst_n && in_tvalid && in_tready;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= '0;
      in_tlast <= 0;
    end else if (!in_tvalid || in_taken) begin
      if (vertex_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 18)) begin
        cur_item = vertex_queue.pop_front();
        in_tvalid <= 1;
        in_tdata <= cur_item.data;
        in_tlast <= cur_item.last;
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off so the input backs up.
  int hold_left = 0;
  bit hold_seen = 0;
  always @(negedge clk) begin
    if (hold_trig != hold_seen) begin
      hold_seen = hold_trig;
      hold_left = 600;
    end
    if (!rst_n) begin
      out_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 0;
    end else begin
      out_tready <= no_idle || $urandom_range(0, 99) >= 18;
    end
  end

  // Monitor: compare each accepted word with the oldest prediction.
  always @(posedge clk) begin
    vout_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (clipped_queue.size() == 0) begin
        $display("%0t unexpected word: got data %h empty %b last %b",
                 $realtime, out_tdata, out_tuser, out_tlast);
        fails++;
      end else begin
        e = clipped_queue.pop_front();
        for (int i = 0; i < fpclip_pkg::NUM_WORDS; i++) begin
          if (out_tdata[i*32 +: 32] !== e.data[i*32 +: 32]) begin
            $display("%0t word %0d mismatch: expected %h actual %h",
                     $realtime, i, e.data[i*32 +: 32], out_tdata[i*32 +: 32]);
            fails++;
          end
        end
        if (out_tuser !== e.empty) begin
          $display("%0t empty mismatch: expected %b actual %b", $realtime, e.empty, out_tuser);
          fails++;
        end
        if (out_tlast !== e.last) begin
          $display("%0t last mismatch: expected %b actual %b", $realtime, e.last, out_tlast);
          fails++;
        end
      end
    end
  end

endmodule

/* filelist.f */
design/fpclip_pkg.sv
design/fpclip_front.sv
design/fpclip_queue.sv
design/fpclip_back.sv
design/frustum_plane_polygon_clip_unit.sv
sim/tb_frustum_plane_polygon_clip_unit.sv
